@@ rtl/usd_pkg.sv @@
// ----------------------------------------------------------------------------
// usd_pkg: shared types and constants for the UTF-8 stream decoder
// Holds the job descriptor that is passed from the front end to the back end.
// ----------------------------------------------------------------------------
package usd_pkg;

  localparam int CP_W            = 21;
  localparam int ERR_CNT_W       = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // One decoded input byte: err_cnt replacement items come first, then the
  // code point when has_cp is set.
  typedef struct packed {
    logic [ERR_CNT_W-1:0] err_cnt;
    logic                 has_cp;
    logic [CP_W-1:0]      cp;
  } job_t;

endpackage

@@ rtl/usd_front.sv @@
// ----------------------------------------------------------------------------
// usd_front: byte classifier and sequence tracker
// Tracks the pending multi-byte sequence and turns each byte into a job.
// ----------------------------------------------------------------------------
module usd_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output logic        job_valid,
  output usd_pkg::job_t job
);
  import usd_pkg::*;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_t;

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [1:0]      need_r, need_nxt;
  logic [1:0]      taken_r, taken_nxt;

  lead_class_t          lead_class;
  logic [1:0]           taken_inc;
  logic [CP_W-1:0]      acc_shift;
  logic [ERR_CNT_W-1:0] err_cnt;
  logic                 has_cp;
  logic [CP_W-1:0]      cp;

  always_comb begin
    unique casez (data_byte)
      8'b0???????: lead_class = LEAD_ASCII;
      8'b110?????: lead_class = LEAD_TWO;
      8'b1110????: lead_class = LEAD_THREE;
      8'b11110???: lead_class = LEAD_FOUR;
      default:     lead_class = LEAD_BAD;
    endcase
  end

  assign taken_inc = taken_r + 2'd1;
  assign acc_shift = {acc_r[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    acc_nxt   = acc_r;
    need_nxt  = need_r;
    taken_nxt = taken_r;
    err_cnt   = '0;
    has_cp    = 1'b0;
    cp        = acc_shift;

    if ((need_r != 2'd0) && (data_byte[7:6] == 2'b10)) begin
      acc_nxt   = acc_shift;
      taken_nxt = taken_inc;
      if (taken_inc >= need_r) begin
        has_cp    = 1'b1;
        acc_nxt   = '0;
        need_nxt  = 2'd0;
        taken_nxt = 2'd0;
      end
    end else begin
      // broken sequence: one replacement for the lead and each continuation
      if (need_r != 2'd0) begin
        err_cnt   = ERR_CNT_W'(taken_r) + ERR_CNT_W'(1);
        acc_nxt   = '0;
        need_nxt  = 2'd0;
        taken_nxt = 2'd0;
      end
      unique case (lead_class)
        LEAD_ASCII: begin
          has_cp = 1'b1;
          cp     = CP_W'(data_byte);
        end
        LEAD_TWO: begin
          acc_nxt   = CP_W'(data_byte[4:0]);
          need_nxt  = 2'd1;
          taken_nxt = 2'd0;
        end
        LEAD_THREE: begin
          acc_nxt   = CP_W'(data_byte[3:0]);
          need_nxt  = 2'd2;
          taken_nxt = 2'd0;
        end
        LEAD_FOUR: begin
          acc_nxt   = CP_W'(data_byte[2:0]);
          need_nxt  = 2'd3;
          taken_nxt = 2'd0;
        end
        default: begin
          err_cnt = err_cnt + ERR_CNT_W'(1);
        end
      endcase
    end

    // flush whatever is still pending at end of stream
    if (stream_end && (need_nxt != 2'd0)) begin
      err_cnt   = err_cnt + ERR_CNT_W'(taken_nxt) + ERR_CNT_W'(1);
      acc_nxt   = '0;
      need_nxt  = 2'd0;
      taken_nxt = 2'd0;
    end
  end

  assign job_valid   = take && ((err_cnt != '0) || has_cp);
  assign job.err_cnt = err_cnt;
  assign job.has_cp  = has_cp;
  assign job.cp      = cp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      need_r  <= 2'd0;
      taken_r <= 2'd0;
    end else if (take) begin
      acc_r   <= acc_nxt;
      need_r  <= need_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

@@ rtl/usd_queue.sv @@
// ----------------------------------------------------------------------------
// usd_queue: job queue between front end and back end
// Small register FIFO so the front end keeps taking bytes during error bursts.
// ----------------------------------------------------------------------------
module usd_queue #(
  parameter int DEPTH = usd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  usd_pkg::job_t wr_job,
  input  logic          rd_en,
  output usd_pkg::job_t rd_job,
  output logic          full,
  output logic          not_empty
);
  import usd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_job    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/usd_back.sv @@
// ----------------------------------------------------------------------------
// usd_back: result sequencer
// Expands each job into its result items, one per cycle while the output slot is popped, into the output slot.
// ----------------------------------------------------------------------------
module usd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  usd_pkg::job_t q_job,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [20:0]   code_point,
  output logic          was_error,
  output logic          last_of_run
);
  import usd_pkg::*;

  job_t            cur_r, cur_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] out_cp_r;
  logic            out_err_r;
  logic            out_last_r;

  job_t            src;
  job_t            rem;
  logic            src_valid;
  logic            rem_busy;
  logic            load;
  logic            out_taken;
  logic [CP_W-1:0] res_cp;
  logic            res_err;

  assign src_valid = cur_valid_r || q_not_empty;
  assign src       = cur_valid_r ? cur_r : q_job;
  assign out_taken = pop && out_valid_r;
  assign load      = src_valid && (!out_valid_r || out_taken);
  assign q_pop     = load && !cur_valid_r;

  // replacement items go out first, then the code point
  always_comb begin
    rem = src;
    if (src.err_cnt != '0) begin
      res_cp      = REPLACEMENT_CP;
      res_err     = 1'b1;
      rem.err_cnt = src.err_cnt - ERR_CNT_W'(1);
      rem_busy    = (src.err_cnt != ERR_CNT_W'(1)) || src.has_cp;
    end else begin
      res_cp      = src.cp;
      res_err     = 1'b0;
      rem.has_cp  = 1'b0;
      rem_busy    = 1'b0;
    end
  end

  always_comb begin
    cur_nxt       = load ? rem : cur_r;
    cur_valid_nxt = load ? rem_busy : cur_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_taken) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load) begin
      out_cp_r   <= res_cp;
      out_err_r  <= res_err;
      out_last_r <= !rem_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty       = !out_valid_r;
  assign code_point  = out_cp_r;
  assign was_error   = out_err_r;
  assign last_of_run = out_last_r;

endmodule

@@ rtl/utf8_stream_decoder_core.sv @@
// A result item reaches the output ports through the job queue and the output slot register.
// Throughput: one byte per cycle while each byte gives at most one result and results are popped.
// A byte giving more than one result holds the back end until its last result is loaded; the job queue
// (QUEUE_DEPTH entries) lets the front end keep taking bytes meanwhile.
// Reset (synchronous, active low) clears sequence state, queue and output slot.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core: UTF-8 byte stream to code point decoder
// Front end classifies bytes, queue decouples, back end emits result items.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core #(
  parameter int QUEUE_DEPTH = usd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        empty,
  input  logic        pop,
  output logic [20:0] out_code_point,
  output logic        out_was_error,
  output logic        out_last_of_run
);
  import usd_pkg::*;

  logic q_full;
  logic q_not_empty;
  logic q_pop;
  logic take;
  logic job_valid;
  job_t job;
  job_t q_job;

  assign full = q_full;
  assign take = push && !q_full;

  usd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_data_byte),
    .stream_end (in_stream_end),
    .job_valid  (job_valid),
    .job        (job)
  );

  usd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (job_valid),
    .wr_job    (job),
    .rd_en     (q_pop),
    .rd_job    (q_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  usd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .code_point  (out_code_point),
    .was_error   (out_was_error),
    .last_of_run (out_last_of_run)
  );

endmodule

@@ test/utf8_stream_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core_tb: self-checking bench for the UTF-8 decoder core
// Feeds directed and random byte streams through the push/full side, predicts
// the code point items in a small scoreboard and checks every popped item.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core_tb;

  import usd_pkg::*;

  localparam int RANDOM_BYTES  = 295;
  localparam int TAIL_BYTES    = 40;
  localparam int DIRECTED_LEN  = 25;
  localparam int SETTLE_CYCLES = 8;

  // Lead and continuation byte tags
  localparam logic       ASCII_TAG = 1'b0;
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            err;
    logic            last;
  } cp_result_t;

  class cp_scoreboard;
    logic [CP_W-1:0] acc;
    logic [1:0]      need;
    logic [1:0]      taken;
    cp_result_t      expected_cps[$];
    cp_result_t      run_q[$];
    int              errors;
    int              bytes_noted;
    int              ends_noted;
    int              results_checked;
    int              replacements_checked;

    function new();
      acc = '0;
      need = '0;
      taken = '0;
      errors = 0;
      bytes_noted = 0;
      ends_noted = 0;
      results_checked = 0;
      replacements_checked = 0;
    endfunction

    function void add_cp(logic [CP_W-1:0] cp, logic err);
      cp_result_t r;
      r.cp = cp;
      r.err = err;
      r.last = 1'b0;
      run_q.push_back(r);
    endfunction

    // One replacement for the lead and one per continuation taken, then idle
    function void flush_seq();
      for (int k = 0; k <= int'(taken); k++) add_cp(REPLACEMENT_CP, 1'b1);
      acc = '0;
      need = '0;
      taken = '0;
    endfunction

    function void take_lead(logic [7:0] b);
      if (b[7] == ASCII_TAG) begin
        add_cp(CP_W'(b), 1'b0);
      end else if (b[7:5] == LEAD2_TAG) begin
        acc = CP_W'(b[4:0]);
        need = 2'd1;
        taken = 2'd0;
      end else if (b[7:4] == LEAD3_TAG) begin
        acc = CP_W'(b[3:0]);
        need = 2'd2;
        taken = 2'd0;
      end else if (b[7:3] == LEAD4_TAG) begin
        acc = CP_W'(b[2:0]);
        need = 2'd3;
        taken = 2'd0;
      end else begin
        add_cp(REPLACEMENT_CP, 1'b1);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic e);
      run_q = {};
      bytes_noted++;
      if (e) ends_noted++;
      if (need != 2'd0) begin
        if (b[7:6] == CONT_TAG) begin
          acc = {acc[CP_W-7:0], b[5:0]};
          taken = taken + 2'd1;
          if (taken >= need) begin
            add_cp(acc, 1'b0);
            acc = '0;
            need = '0;
            taken = '0;
          end
        end else begin
          // replace the pending sequence with replacement items and treat this byte as a fresh lead
          flush_seq();
          take_lead(b);
        end
      end else begin
        take_lead(b);
      end
      if (e && need != 2'd0) flush_seq();
      foreach (run_q[i]) begin
        if (i == run_q.size() - 1) run_q[i].last = 1'b1;
        expected_cps.push_back(run_q[i]);
      end
    endfunction

    function void check_result(logic [CP_W-1:0] cp, logic err, logic last);
      cp_result_t exp_r;
      if (expected_cps.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual cp=%h err=%b last=%b",
                 $time, cp, err, last);
        errors++;
        return;
      end
      exp_r = expected_cps.pop_front();
      results_checked++;
      if (err) replacements_checked++;
      if (cp !== exp_r.cp) begin
        $display("%0t: code_point expected %h actual %h", $time, exp_r.cp, cp);
        errors++;
      end
      if (err !== exp_r.err) begin
        $display("%0t: was_error expected %b actual %b", $time, exp_r.err, err);
        errors++;
      end
      if (last !== exp_r.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, exp_r.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_cps.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_stream_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [20:0] out_code_point;
  logic        out_was_error;
  logic        out_last_of_run;

  cp_scoreboard sb = new();

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int bytes_sent = 0;
  int rx_hold = 0;

  // {stream_end, data_byte}
  localparam logic [8:0] DIRECTED [DIRECTED_LEN] = '{
    9'h000, 9'h07F,                   // smallest and largest single byte
    9'h0C2, 9'h0A9,                   // two-byte form
    9'h0EF, 9'h0BF, 9'h0BD,           // literal replacement character
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,   // largest four-byte value
    9'h080, 9'h0FF,                   // invalid leads
    9'h0E2, 9'h082, 9'h041,           // broken sequence, then ASCII
    9'h0F0, 9'h090, 9'h080, 9'h1E2,   // broken sequence re-led and flushed at end
    9'h1C2,                           // end flush of a bare lead
    9'h141,                           // end on a complete byte
    9'h0ED, 9'h0A0, 9'h080            // surrogate passes through
  };

  utf8_stream_decoder_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data_byte   (in_data_byte),
    .in_stream_end  (in_stream_end),
    .empty          (empty),
    .pop            (pop),
    .out_code_point (out_code_point),
    .out_was_error  (out_was_error),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: pop with random stall bursts
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      pop <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      rx_hold = $urandom_range(0, 16);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_code_point, out_was_error, out_last_of_run);
  end

  function automatic logic rand_end();
    return ($urandom_range(0, 19) == 0);
  endfunction

  function automatic logic [7:0] cont_byte();
    return {CONT_TAG, 6'($urandom)};
  endfunction

  function automatic logic [7:0] lead_byte(int len);
    case (len)
      1: return {ASCII_TAG, 7'($urandom)};
      2: return {LEAD2_TAG, 5'($urandom)};
      3: return {LEAD3_TAG, 4'($urandom)};
      default: return {LEAD4_TAG, 3'($urandom)};
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_stream_end <= e;
    do @(posedge clk); while (full);
    sb.note_byte(b, e);
    bytes_sent++;
  endtask

  // Hold the sender until every predicted item has been popped
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic send_random_group();
    int kind;
    int len;
    int n_cont;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      len = $urandom_range(1, 4);
      send_byte(lead_byte(len), rand_end());
      for (int k = 1; k < len; k++) send_byte(cont_byte(), rand_end());
    end else if (kind == 7) begin
      // truncated sequence cut short by a byte that is not a continuation
      len = $urandom_range(2, 4);
      n_cont = $urandom_range(0, len - 2);
      send_byte(lead_byte(len), 1'b0);
      for (int k = 0; k < n_cont; k++) send_byte(cont_byte(), 1'b0);
      b = 8'($urandom);
      if (b[7:6] == CONT_TAG) b[6] = 1'b1;
      send_byte(b, rand_end());
    end else begin
      send_byte(8'($urandom), rand_end());
    end
  endtask

  initial begin
    int rnd_count;
    bit paused;
    paused = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    rnd_count = 0;
    while (rnd_count < RANDOM_BYTES) begin
      // no random idles in a stretch in the middle, and none at all in the tail
      tx_idle_en = !(rnd_count >= 140 && rnd_count < 190) && rnd_count < RANDOM_BYTES - TAIL_BYTES;
      rx_idle_en = tx_idle_en;
      if (!paused && rnd_count >= 220) begin
        wait_drained();
        paused = 1'b1;
      end
      send_random_group();
      rnd_count = bytes_sent - DIRECTED_LEN;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() > 0) begin
      $display("%0t: %0d expected items never arrived", $time, sb.pending());
      sb.errors += sb.pending();
    end

    $display("Decoded %0d bytes (%0d with stream end) into %0d items, %0d of them errors.",
             sb.bytes_noted, sb.ends_noted, sb.results_checked, sb.replacements_checked);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("%0t: timeout, %0d items still expected", $time, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
